// ----- rtl/core/rpfa_pkg.sv -----
// Shared types and constants for the reference-counted page frame allocator.
// No dependencies; imported by refcounted_page_frame_allocator_unit.
package rpfa_pkg;

  localparam int PAGE_W         = 15;
  localparam int LIMIT_W        = 16;
  localparam int RC_W           = 8;
  localparam int KIND_W         = 3;
  localparam int STATUS_W       = 3;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 16;
  localparam int NUM_PAGES_DEF  = 32768;
  localparam int COUNT_BITS_DEF = 8;
  localparam logic [LIMIT_W-1:0] PAGE_LIMIT_RST = 16'd32768;

  typedef enum logic [KIND_W-1:0] {
    K_ALLOC   = 3'd0,
    K_RELEASE = 3'd1,
    K_ADD_REF = 3'd2,
    K_READ    = 3'd3,
    K_INIT    = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_FREE   = 3'd1,
    ST_BAD_PAGE  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_SATURATED = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_PAGE = 1'b0,
    CFG_PAGE_LIMIT = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_INIT
  } state_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [RC_W-1:0]   count;
    status_t           status;
  } res_t;

endpackage

// ----- rtl/core/refcounted_page_frame_allocator_unit.sv -----
// Reference-counted page frame allocator: LIFO free stack plus per-page count table.
// Depends on rpfa_pkg. Each alloc/release/add_ref/read_count item is accepted with a memory
// read, then executed and written back once the output slot is free; init walks pages from
// first to limit, one page per cycle through the single write port of each memory.
// A new item is accepted only when idle, after the previous result has been loaded.
// Reset: clears stack_top and control; count table and stack are undefined until init.
module refcounted_page_frame_allocator_unit #(
  parameter int NUM_PAGES  = rpfa_pkg::NUM_PAGES_DEF,
  parameter int COUNT_BITS = rpfa_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rpfa_pkg::KIND_W-1:0]   kind,
  input  logic [rpfa_pkg::PAGE_W-1:0]   page,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rpfa_pkg::PAGE_W-1:0]   out_page,
  output logic [rpfa_pkg::RC_W-1:0]     ref_count,
  output logic [rpfa_pkg::STATUS_W-1:0] status,
  input  logic                          cfg_we,
  input  logic [rpfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpfa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rpfa_pkg::*;

  localparam int ADDR_W = $clog2(NUM_PAGES);
  localparam int TOP_W  = $clog2(NUM_PAGES + 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  // Page state memories: one read and one write port each, registered read.
  logic [COUNT_BITS-1:0] count_mem [NUM_PAGES];
  logic [PAGE_W-1:0]     stack_mem [NUM_PAGES];

  // Configuration registers.
  logic [PAGE_W-1:0]  first_page;
  logic [LIMIT_W-1:0] page_limit;

  // Control state.
  state_t             state, state_next;
  logic [TOP_W-1:0]   top, top_next;
  logic [LIMIT_W-1:0] cursor, cursor_next;
  logic [KIND_W-1:0]  kind_q;
  logic [PAGE_W-1:0]  page_q;

  // Memory ports.
  logic [COUNT_BITS-1:0] cnt_rd;
  logic [PAGE_W-1:0]     stk_rd;
  logic                  cnt_we, stk_we;
  logic [ADDR_W-1:0]     cnt_wa, stk_wa;
  logic [COUNT_BITS-1:0] cnt_wd;
  logic [PAGE_W-1:0]     stk_wd;

  logic        in_fire, slot_free, load_out;
  res_t        res;
  logic [31:0] page_ext, pageq_ext, stk_ext, cursor_ext, cnt_ext, lim32;
  logic [TOP_W-1:0] top_m1;
  logic        page_ok;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  assign page_ext   = 32'(page);
  assign pageq_ext  = 32'(page_q);
  assign stk_ext    = 32'(stk_rd);
  assign cursor_ext = 32'(cursor);
  assign cnt_ext    = 32'(cnt_rd);
  assign top_m1     = top - TOP_W'(1);
  assign lim32      = (32'(page_limit) < 32'(NUM_PAGES)) ? 32'(page_limit) : 32'(NUM_PAGES);

  // Managed range check for the held item's page.
  assign page_ok = (page_q >= first_page) && (pageq_ext < 32'(page_limit)) &&
                   (pageq_ext < 32'(NUM_PAGES));

  // Configuration writes; only taken while the block is idle: the user is bound, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_page <= '0;
      page_limit <= PAGE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_PAGE: first_page <= cfg_wdata[PAGE_W-1:0];
        CFG_PAGE_LIMIT: page_limit <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read both memories in the accept cycle: count at the item's page, stack at top-1.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cnt_rd <= count_mem[page_ext[ADDR_W-1:0]];
      stk_rd <= stack_mem[top_m1[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      count_mem[cnt_wa] <= cnt_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_wa] <= stk_wd;
    end
  end

  // Hold the accepted item for the execute or init phase.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_q <= kind;
      page_q <= page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      top    <= '0;
      cursor <= '0;
    end else begin
      state  <= state_next;
      top    <= top_next;
      cursor <= cursor_next;
    end
  end

  // Next state, memory write-back and result formation.
  always_comb begin
    state_next  = state;
    top_next    = top;
    cursor_next = cursor;
    cnt_we      = 1'b0;
    cnt_wa      = pageq_ext[ADDR_W-1:0];
    cnt_wd      = '0;
    stk_we      = 1'b0;
    stk_wa      = top[ADDR_W-1:0];
    stk_wd      = page_q;
    load_out    = 1'b0;
    res         = '{page: page_q, count: '0, status: ST_OK};

    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (kind == K_INIT) begin
            // Restart the stack and walk pages from first_page upward.
            state_next  = S_INIT;
            top_next    = '0;
            cursor_next = LIMIT_W'(first_page);
          end else if (kind inside {K_ALLOC, K_RELEASE, K_ADD_REF, K_READ}) begin
            state_next = S_EXEC;
          end
          // Unknown kinds: drop, no result.
        end
      end

      S_EXEC: begin
        case (kind_q)
          K_ALLOC: begin
            if (top == '0) begin
              res = '{page: '0, count: '0, status: ST_NO_FREE};
            end else begin
              res = '{page: stk_rd, count: RC_W'(1), status: ST_OK};
              cnt_wa = stk_ext[ADDR_W-1:0];
              cnt_wd = COUNT_ONE;
              if (slot_free) begin
                cnt_we   = (stk_ext < 32'(NUM_PAGES));
                top_next = top_m1;
              end
            end
          end
          K_RELEASE: begin
            if (!page_ok) begin
              res.status = ST_BAD_PAGE;
            end else if (cnt_rd == '0) begin
              res.status = ST_UNDERFLOW;
            end else if (cnt_rd == COUNT_ONE && 32'(top) >= 32'(NUM_PAGES)) begin
              res.count  = cnt_ext[RC_W-1:0];
              res.status = ST_FULL;
            end else begin
              cnt_wd    = cnt_rd - COUNT_ONE;
              res.count = RC_W'(32'(cnt_wd));
              if (slot_free) begin
                cnt_we = 1'b1;
                // Last reference gone: push the page back on the free stack.
                if (cnt_rd == COUNT_ONE) begin
                  stk_we   = 1'b1;
                  top_next = top + TOP_W'(1);
                end
              end
            end
          end
          K_ADD_REF: begin
            if (!page_ok) begin
              res.status = ST_BAD_PAGE;
            end else if (cnt_rd == COUNT_MAX) begin
              res.count  = cnt_ext[RC_W-1:0];
              res.status = ST_SATURATED;
            end else begin
              cnt_wd    = cnt_rd + COUNT_ONE;
              res.count = RC_W'(32'(cnt_wd));
              cnt_we    = slot_free;
            end
          end
          K_READ: begin
            if (!page_ok) begin
              res.status = ST_BAD_PAGE;
            end else begin
              res.count = cnt_ext[RC_W-1:0];
            end
          end
          default: ;
        endcase
        if (slot_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_INIT: begin
        if (cursor_ext < lim32) begin
          // One page per cycle: clear its count and push it.
          cnt_we      = 1'b1;
          cnt_wa      = cursor_ext[ADDR_W-1:0];
          cnt_wd      = '0;
          stk_we      = 1'b1;
          stk_wd      = cursor[PAGE_W-1:0];
          top_next    = top + TOP_W'(1);
          cursor_next = cursor + LIMIT_W'(1);
        end else if (slot_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Output register: parts the result from the input side.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_page  <= res.page;
      ref_count <= res.count;
      status    <= res.status;
    end
  end

`ifndef SYNTHESIS
  // The stack never holds more pages than exist.
  a_top_bound: assert property (@(posedge clk) disable iff (rst)
    32'(top) <= 32'(NUM_PAGES))
    else $error("stack_top beyond page count");

  // Interlock: no memory write-back while a new item's read is issued.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> !cnt_we && !stk_we)
    else $error("memory write overlaps accept");

  // A result is loaded only from the execute or init phase.
  a_load_src: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (state == S_EXEC || state == S_INIT))
    else $error("result loaded outside execute/init");

  // A successful alloc pops exactly one page.
  a_alloc_pop: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && kind_q == K_ALLOC && top != '0 && slot_free)
      |=> top == $past(top) - TOP_W'(1))
    else $error("alloc did not pop the stack");
`endif

endmodule
